### hdl/hpp_pkg.sv
package hpp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W = 18;
    localparam int IN_W   = 17;
    localparam int OUT_W  = 32;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_HORIZON  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_LIMITS   = 3'd4
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_TOP    = 3'd0,
        REG_ROW_MIDDLE = 3'd1,
        REG_ROW_BOTTOM = 3'd2,
        REG_X_LIMITS   = 3'd3,
        REG_Y_LIMITS   = 3'd4,
        REG_LIMITS_EN  = 3'd5,
        REG_MIN_DEN    = 3'd6
    } t_reg_index;

    typedef struct packed {
        logic [IN_W-1:0] u;
        logic [IN_W-1:0] v;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [OUT_W-1:0] local_x;
        logic signed [OUT_W-1:0] local_y;
    } t_out_beat;

    typedef struct packed {
        logic [53:0] row_top;
        logic [53:0] row_middle;
        logic [53:0] row_bottom;
        logic [63:0] x_limits;
        logic [63:0] y_limits;
        logic        limits_enable;
        logic [16:0] min_denominator;
    } t_cfg;

endpackage

### hdl/hpp_div_stage.sv
// One restoring division step per instance; one quotient bit per stage.
module hpp_div_stage import hpp_pkg::*; #(
    parameter int QW = 48,
    parameter int DW = 40
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [QW-1:0] i_rem_q,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_rem_q,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den
);
    logic [DW:0]   n_trial;
    logic [DW:0]   n_sub;
    logic          n_bit;

    always_comb begin
        n_trial = {i_rem, i_rem_q[QW-1]};
        n_sub   = n_trial - {1'b0, i_den};
        n_bit   = !n_sub[DW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem   <= n_bit ? n_sub[DW-1:0] : n_trial[DW-1:0];
            o_rem_q <= {i_rem_q[QW-2:0], n_bit};
            o_den   <= i_den;
        end
    end
endmodule

### hdl/homography_point_projection.sv
// Homography point projection. A point (u, v) is accepted every cycle unless
// a result waits at the output with i_out_ready low. The pipeline holds three
// dot-product stages, one overflow pre-check stage, the bit-per-stage divider
// (32 integer and FRAC_BITS fraction quotient bits) and a final check stage.
// A stall freezes the whole pipeline. Configuration must be written through
// i_cfg_we/i_cfg_index/i_cfg_data while the pipeline is empty (not enforced).
module homography_point_projection import hpp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_beat
);
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * F + 24;          // dot product width
    localparam int DW   = PW;                  // divisor/remainder width
    localparam int NQ   = 32 + F;              // quotient bits generated
    localparam int QW   = PW + F;              // dividend shift width
    localparam int NS   = NQ + 5;              // total stages
    localparam logic [IN_W-1:0] ONE = IN_W'(1) << F;

    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{row_top: '0, row_middle: '0, row_bottom: '0, x_limits: '0,
                       y_limits: '0, limits_enable: 1'b0, min_denominator: 17'd1};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_TOP:    r_cfg.row_top <= i_cfg_data[53:0];
                REG_ROW_MIDDLE: r_cfg.row_middle <= i_cfg_data[53:0];
                REG_ROW_BOTTOM: r_cfg.row_bottom <= i_cfg_data[53:0];
                REG_X_LIMITS:   r_cfg.x_limits <= i_cfg_data;
                REG_Y_LIMITS:   r_cfg.y_limits <= i_cfg_data;
                REG_LIMITS_EN:  r_cfg.limits_enable <= i_cfg_data[0];
                REG_MIN_DEN:    r_cfg.min_denominator <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // pipeline control: whole pipe advances when output is free
    logic [NS-1:0] r_vld;
    logic          w_adv;
    assign w_adv = !r_vld[NS-1] || i_out_ready;
    assign o_in_ready = w_adv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= {r_vld[NS-2:0], i_in_valid};
    end

    function automatic logic signed [COEF_W-1:0] coef(input logic [53:0] row, input int s);
        return row[COEF_W*s +: COEF_W];
    endfunction

    // stage 1: products
    logic signed [2*COEF_W-1:0] w_pu [3];
    logic signed [2*COEF_W-1:0] w_pv [3];
    always_comb begin
        w_pu[0] = coef(r_cfg.row_top, 0) * $signed({1'b0, i_in_beat.u});
        w_pv[0] = coef(r_cfg.row_top, 1) * $signed({1'b0, i_in_beat.v});
        w_pu[1] = coef(r_cfg.row_middle, 0) * $signed({1'b0, i_in_beat.u});
        w_pv[1] = coef(r_cfg.row_middle, 1) * $signed({1'b0, i_in_beat.v});
        w_pu[2] = coef(r_cfg.row_bottom, 0) * $signed({1'b0, i_in_beat.u});
        w_pv[2] = coef(r_cfg.row_bottom, 1) * $signed({1'b0, i_in_beat.v});
    end

    logic signed [PW-1:0] r_p [3][3];
    logic                 r_bad1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bad1 <= (i_in_beat.u > ONE) || (i_in_beat.v > ONE);
            r_p[0][0] <= PW'(w_pu[0]);
            r_p[0][1] <= PW'(w_pv[0]);
            r_p[0][2] <= PW'(coef(r_cfg.row_top, 2)) <<< F;
            r_p[1][0] <= PW'(w_pu[1]);
            r_p[1][1] <= PW'(w_pv[1]);
            r_p[1][2] <= PW'(coef(r_cfg.row_middle, 2)) <<< F;
            r_p[2][0] <= PW'(w_pu[2]);
            r_p[2][1] <= PW'(w_pv[2]);
            r_p[2][2] <= PW'(coef(r_cfg.row_bottom, 2)) <<< F;
        end
    end

    // stage 2: dot products
    logic signed [PW-1:0] r_nx, r_ny, r_den;
    logic                 r_bad2;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bad2 <= r_bad1;
            r_nx  <= r_p[0][0] + r_p[0][1] + r_p[0][2];
            r_ny  <= r_p[1][0] + r_p[1][1] + r_p[1][2];
            r_den <= r_p[2][0] + r_p[2][1] + r_p[2][2];
        end
    end

    // stage 3: status prefilter, magnitudes
    logic [2:0]    r_st3;
    logic [PW-1:0] r_ax, r_ay, r_d3;
    logic          r_sx3, r_sy3;
    logic signed [PW-1:0] w_thr;
    assign w_thr = $signed({{(PW-17){1'b0}}, r_cfg.min_denominator}) <<< F;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_bad2) r_st3 <= ST_RANGE;
            else if (r_den <= w_thr) r_st3 <= ST_HORIZON;
            else r_st3 <= ST_OK;
            r_ax  <= r_nx[PW-1] ? PW'(-r_nx) : r_nx;
            r_ay  <= r_ny[PW-1] ? PW'(-r_ny) : r_ny;
            r_sx3 <= r_nx[PW-1];
            r_sy3 <= r_ny[PW-1];
            r_d3  <= r_den;
        end
    end

    // divider chain: quotient = (a << F) / d, NQ bits kept, high bits checked
    logic [QW-1:0] w_qx [NQ+1];
    logic [QW-1:0] w_qy [NQ+1];
    logic [DW-1:0] w_rx [NQ+1];
    logic [DW-1:0] w_ry [NQ+1];
    logic [DW-1:0] w_dx [NQ+1];
    logic [DW-1:0] w_dy [NQ+1];
    logic [2:0]    r_st [NQ+1];
    logic          r_sx [NQ+1];
    logic          r_sy [NQ+1];
    logic          r_hx [NQ+1];
    logic          r_hy [NQ+1];
    logic [QW-1:0] w_ax0, w_ay0;
    logic [DW:0]   w_ox, w_oy;

    // pre-step: quotient bits above NQ are nonzero iff top of dividend >= d
    assign w_ax0 = {r_ax, {F{1'b0}}};
    assign w_ay0 = {r_ay, {F{1'b0}}};
    assign w_ox = {1'b0, DW'(w_ax0[QW-1 -: (QW-NQ)])} - {1'b0, r_d3};
    assign w_oy = {1'b0, DW'(w_ay0[QW-1 -: (QW-NQ)])} - {1'b0, r_d3};
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            w_qx[0] <= w_ax0 << (QW - NQ);
            w_qy[0] <= w_ay0 << (QW - NQ);
            w_rx[0] <= DW'(w_ax0[QW-1 -: (QW-NQ)]);
            w_ry[0] <= DW'(w_ay0[QW-1 -: (QW-NQ)]);
            w_dx[0] <= r_d3;
            w_dy[0] <= r_d3;
            r_hx[0] <= !w_ox[DW] && (r_st3 == ST_OK);
            r_hy[0] <= !w_oy[DW] && (r_st3 == ST_OK);
            r_st[0] <= r_st3;
            r_sx[0] <= r_sx3;
            r_sy[0] <= r_sy3;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_div
        hpp_div_stage #(.QW(QW), .DW(DW)) u_dx (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem_q(w_qx[k]), .i_rem(w_rx[k]), .i_den(w_dx[k]),
            .o_rem_q(w_qx[k+1]), .o_rem(w_rx[k+1]), .o_den(w_dx[k+1]));
        hpp_div_stage #(.QW(QW), .DW(DW)) u_dy (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem_q(w_qy[k]), .i_rem(w_ry[k]), .i_den(w_dy[k]),
            .o_rem_q(w_qy[k+1]), .o_rem(w_ry[k+1]), .o_den(w_dy[k+1]));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[k+1] <= r_st[k];
                r_sx[k+1] <= r_sx[k];
                r_sy[k+1] <= r_sy[k];
                r_hx[k+1] <= r_hx[k];
                r_hy[k+1] <= r_hy[k];
            end
        end
    end

    // final: sign, overflow, limits
    logic [NQ-1:0]           w_mx, w_my;
    logic                    w_ovx, w_ovy, w_lim;
    logic signed [OUT_W-1:0] w_x, w_y;
    logic [2:0]              n_st;
    assign w_mx = w_qx[NQ][NQ-1:0];
    assign w_my = w_qy[NQ][NQ-1:0];
    always_comb begin
        w_ovx = r_hx[NQ] || (r_sx[NQ] ? (w_mx > NQ'(33'h80000000))
                                      : (w_mx > NQ'(32'h7FFFFFFF)));
        w_ovy = r_hy[NQ] || (r_sy[NQ] ? (w_my > NQ'(33'h80000000))
                                      : (w_my > NQ'(32'h7FFFFFFF)));
        w_x = r_sx[NQ] ? OUT_W'(-w_mx) : OUT_W'(w_mx);
        w_y = r_sy[NQ] ? OUT_W'(-w_my) : OUT_W'(w_my);
        w_lim = r_cfg.limits_enable &&
            ((w_x < $signed(r_cfg.x_limits[63:32])) ||
             (w_x > $signed(r_cfg.x_limits[31:0])) ||
             (w_y < $signed(r_cfg.y_limits[63:32])) ||
             (w_y > $signed(r_cfg.y_limits[31:0])));
        if (r_st[NQ] != ST_OK) n_st = r_st[NQ];
        else if (w_ovx || w_ovy) n_st = ST_OVERFLOW;
        else if (w_lim) n_st = ST_LIMITS;
        else n_st = ST_OK;
    end

    t_out_beat r_out;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.status  <= n_st;
            r_out.local_x <= (n_st == ST_OK) ? w_x : '0;
            r_out.local_y <= (n_st == ST_OK) ? w_y : '0;
        end
    end
    assign o_out_beat  = r_out;
    assign o_out_valid = r_vld[NS-1];
endmodule

### hdl/hpp_checker.sv
module hpp_checker import hpp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready) else $error("ready while stalled");
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.status <= ST_LIMITS)) else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_OK) |->
        (o_out_beat.local_x == 0 && o_out_beat.local_y == 0)) else $error("payload not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("beat dropped");
endmodule

bind homography_point_projection hpp_checker u_hpp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_beat(o_out_beat));

### test/homography_point_projection_tb.sv
`timescale 1ns / 100ps

module homography_point_projection_tb import hpp_pkg::*;;

    localparam int FB        = FRAC_BITS;
    localparam int LATENCY   = FB + 37;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 700;
    localparam logic [16:0] ONE = 17'h10000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_beat         i_in_beat = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_beat        o_out_beat;

    homography_point_projection uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow configuration
    logic [53:0] sh_top, sh_mid, sh_bot;
    logic [63:0] sh_xlim, sh_ylim;
    logic        sh_len;
    logic [16:0] sh_minden;

    t_out_beat   pending_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          start_hold = 1'b0;
    bit          stim_done = 1'b0;

    function automatic longint coef_of(logic [53:0] row, int slot);
        logic signed [17:0] c;
        c = row[18*slot +: 18];
        return longint'(c);
    endfunction

    function automatic longint row_dot(logic [53:0] row, longint u, longint v);
        return coef_of(row, 0) * u + coef_of(row, 1) * v + (coef_of(row, 2) <<< FB);
    endfunction

    // returns 0 on overflow
    function automatic bit fixed_quot(longint num, longint den, output longint res);
        logic [63:0] a, q, r, d;
        d = den;
        a = (num < 0) ? -num : num;
        q = a / d;
        r = a % d;
        res = 0;
        if (q >= 64'h1_0000_0000) return 1'b0;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        if (num < 0) begin
            if (q > 64'h8000_0000) return 1'b0;
            res = -longint'(q);
        end else begin
            if (q > 64'h7FFF_FFFF) return 1'b0;
            res = longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic t_out_beat project_point(t_in_beat b);
        t_out_beat o;
        longint u, v, den, nx, ny, x, y;
        o = '0;
        if (b.u > ONE || b.v > ONE) begin
            o.status = ST_RANGE;
            return o;
        end
        u = b.u;
        v = b.v;
        den = row_dot(sh_bot, u, v);
        if (den <= (longint'(sh_minden) <<< FB)) begin
            o.status = ST_HORIZON;
            return o;
        end
        nx = row_dot(sh_top, u, v);
        ny = row_dot(sh_mid, u, v);
        if (!fixed_quot(nx, den, x) || !fixed_quot(ny, den, y)) begin
            o.status = ST_OVERFLOW;
            return o;
        end
        if (sh_len && (x < longint'($signed(sh_xlim[63:32]))
                || x > longint'($signed(sh_xlim[31:0]))
                || y < longint'($signed(sh_ylim[63:32]))
                || y > longint'($signed(sh_ylim[31:0])))) begin
            o.status = ST_LIMITS;
            return o;
        end
        o.status = ST_OK;
        o.local_x = x[31:0];
        o.local_y = y[31:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, t_out_beat got, t_out_beat exp);
        $display("mismatch %s: got st=%0d x=%h y=%h exp st=%0d x=%h y=%h", what,
                 got.status, got.local_x, got.local_y, exp.status, exp.local_x, exp.local_y);
        errors++;
    endtask

    task automatic write_reg(t_reg_index idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_ROW_TOP:    sh_top = val[53:0];
            REG_ROW_MIDDLE: sh_mid = val[53:0];
            REG_ROW_BOTTOM: sh_bot = val[53:0];
            REG_X_LIMITS:   sh_xlim = val;
            REG_Y_LIMITS:   sh_ylim = val;
            REG_LIMITS_EN:  sh_len = val[0];
            REG_MIN_DEN:    sh_minden = val[16:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [17:0] rnd_coef();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'($urandom_range(0, 2 * FB * 4096)) - 18'd65536;
            default: return 18'($urandom);
        endcase
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one beat; exp_fixed used when check_fixed set; valid stays up for back to back
    task automatic send_point(t_in_beat b, bit check_fixed, t_out_beat exp_fixed);
        t_out_beat e;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        e = check_fixed ? exp_fixed : project_point(b);
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_q.push_back(e);
    endtask

    task automatic random_config(bit extreme);
        write_reg(REG_ROW_TOP, {10'd0, rnd_coef(), rnd_coef(), rnd_coef()});
        write_reg(REG_ROW_MIDDLE, {10'd0, rnd_coef(), rnd_coef(), rnd_coef()});
        if (extreme)
            write_reg(REG_ROW_BOTTOM, {$urandom, $urandom});
        else
            write_reg(REG_ROW_BOTTOM, {10'd0, 18'($urandom_range(0, 40000)),
                18'($urandom_range(0, 8000)) - 18'd4000,
                18'($urandom_range(0, 8000)) - 18'd4000});
        write_reg(REG_X_LIMITS, {32'($urandom_range(0, 1 << 22)) - 32'd4194304,
                                 32'($urandom_range(0, 1 << 22))});
        write_reg(REG_Y_LIMITS, extreme ? {$urandom, $urandom}
                  : {32'($urandom_range(0, 1 << 22)) - 32'd4194304,
                     32'($urandom_range(0, 1 << 22))});
        write_reg(REG_LIMITS_EN, 64'($urandom_range(0, 1)));
        write_reg(REG_MIN_DEN, extreme ? 64'($urandom_range(0, 1) ? 65536 : 0)
                  : 64'($urandom_range(0, 300)));
    endtask

    // output side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", o_out_beat, '0);
            end else begin
                t_out_beat e;
                e = pending_q.pop_front();
                if (o_out_beat.status !== e.status) report_mismatch("status", o_out_beat, e);
                else if (o_out_beat.local_x !== e.local_x) report_mismatch("x", o_out_beat, e);
                else if (o_out_beat.local_y !== e.local_y) report_mismatch("y", o_out_beat, e);
            end
        end
    end

    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) i_out_ready <= 1'b0;
        else if (r < 60) i_out_ready <= 1'b1;
        else if (r < 95) i_out_ready <= ($urandom_range(0, 1) == 1);
        else i_out_ready <= 1'b0;
    end

    // long receiver hold-off to fill the pipeline
    initial begin
        wait (start_hold);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n
            || (stim_done && pending_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    typedef struct {
        logic [16:0] u;
        logic [16:0] v;
        bit          fixed;
        logic [2:0]  st;
    } t_row;

    t_row dir_rows[$];

    initial begin
        t_in_beat b;
        t_out_beat e;
        sh_top = '0; sh_mid = '0; sh_bot = '0; sh_xlim = '0; sh_ylim = '0;
        sh_len = 1'b0; sh_minden = 17'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero denominator -> horizon; out of range wins
        dir_rows = '{
            '{17'd0, 17'd0, 1, ST_HORIZON},
            '{ONE, ONE, 1, ST_HORIZON},
            '{ONE + 17'd1, 17'd0, 1, ST_RANGE},
            '{17'd0, 17'h1FFFF, 1, ST_RANGE},
            '{17'h1FFFF, 17'h1FFFF, 1, ST_RANGE}
        };
        foreach (dir_rows[i]) begin
            b.u = dir_rows[i].u; b.v = dir_rows[i].v;
            e = '0; e.status = dir_rows[i].st;
            send_point(b, 1'b1, e);
        end
        drain();

        // identity, den = 1.0, threshold 0
        write_reg(REG_ROW_TOP, {10'd0, 18'd0, 18'd0, 18'h10000});
        write_reg(REG_ROW_MIDDLE, {10'd0, 18'd0, 18'h10000, 18'd0});
        write_reg(REG_ROW_BOTTOM, {10'd0, 18'h10000, 18'd0, 18'd0});
        write_reg(REG_MIN_DEN, 64'd0);
        dir_rows = '{
            '{17'd0, 17'd0, 0, 0}, '{ONE, ONE, 0, 0}, '{ONE, 17'd0, 0, 0},
            '{17'd12345, 17'd54321, 0, 0}, '{ONE + 17'd1, ONE, 1, ST_RANGE}
        };
        foreach (dir_rows[i]) begin
            b.u = dir_rows[i].u; b.v = dir_rows[i].v;
            e = '0; e.status = dir_rows[i].st;
            send_point(b, dir_rows[i].fixed, e);
        end
        drain();

        // threshold at 1.0: den equal to it -> horizon
        write_reg(REG_MIN_DEN, 64'd65536);
        b.u = 17'd0; b.v = 17'd0; e = '0; e.status = ST_HORIZON;
        send_point(b, 1'b1, e);
        drain();

        // tiny denominator -> overflow; limits and inverted limits
        write_reg(REG_MIN_DEN, 64'd0);
        write_reg(REG_ROW_TOP, {10'd0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
        write_reg(REG_ROW_BOTTOM, {10'd0, 18'd1, 18'd0, 18'd0});
        b.u = ONE; b.v = ONE;
        send_point(b, 1'b0, e);
        drain();
        write_reg(REG_ROW_TOP, {10'd0, 18'h20000, 18'h20000, 18'h20000});
        send_point(b, 1'b0, e);
        drain();
        write_reg(REG_ROW_TOP, {10'd0, 18'd0, 18'd0, 18'h10000});
        write_reg(REG_ROW_BOTTOM, {10'd0, 18'h10000, 18'd0, 18'd0});
        write_reg(REG_X_LIMITS, {32'h0000_0000, 32'h0000_8000});
        write_reg(REG_Y_LIMITS, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_LIMITS_EN, 64'd1);
        b.u = 17'd100; b.v = 17'd5; send_point(b, 1'b0, e);
        b.u = ONE; b.v = 17'd5; send_point(b, 1'b0, e);
        drain();
        write_reg(REG_X_LIMITS, {32'h0001_0000, 32'h0000_0000});
        b.u = 17'd0; b.v = 17'd0; e = '0; e.status = ST_LIMITS;
        send_point(b, 1'b1, e);
        drain();

        // random phases
        for (int p = 0; p < 14; p++) begin
            random_config(p % 4 == 3);
            if (p == 5) start_hold = 1'b1;
            for (int k = 0; k < N_RANDOM / 14; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    b.u = 17'($urandom); b.v = 17'($urandom);
                end else begin
                    b.u = 17'($urandom_range(0, 65536));
                    b.v = 17'($urandom_range(0, 65536));
                end
                send_point(b, 1'b0, e);
            end
            drain();
        end

        stim_done = 1'b1;
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
